@@ rtl/json_token_lexer_unit_macros.svh @@
// Assertion macros for the JSON token lexer checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef JSON_TOKEN_LEXER_UNIT_MACROS_SVH
`define JSON_TOKEN_LEXER_UNIT_MACROS_SVH

// same-cycle implication
`define JTL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jtl assertion failed");

// next-cycle implication
`define JTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jtl assertion failed");

`endif

@@ rtl/jtl_pkg.sv @@
// Types, character codes, token kinds and literal tables for the JSON token lexer.
// No dependencies; used by json_token_lexer_unit and jtl_checker.
package jtl_pkg;

  localparam int OFFSET_BITS = 32;

  typedef logic [OFFSET_BITS-1:0] pos_t;
  typedef logic [31:0]            ofs_out_t;
  typedef logic [3:0]             kind_t;
  typedef logic [2:0]             err_t;
  typedef logic [1:0]             sel_t;
  typedef logic [2:0]             prog_t;
  typedef logic [7:0]             char_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_INT,
    M_FRAC,
    M_EXPS,
    M_EXPSIGN,
    M_EXPD,
    M_STR,
    M_ESC,
    M_LIT
  } mode_t;

  typedef struct packed {
    kind_t    kind;
    ofs_out_t start_ofs;
    ofs_out_t end_ofs;
    err_t     err;
  } rec_t;

  localparam kind_t KIND_INT    = 4'd0;
  localparam kind_t KIND_FLOAT  = 4'd1;
  localparam kind_t KIND_STRING = 4'd2;
  localparam kind_t KIND_BOOL   = 4'd3;
  localparam kind_t KIND_NULL   = 4'd4;
  localparam kind_t KIND_LBRACE = 4'd5;
  localparam kind_t KIND_RBRACE = 4'd6;
  localparam kind_t KIND_LBRACK = 4'd7;
  localparam kind_t KIND_RBRACK = 4'd8;
  localparam kind_t KIND_COLON  = 4'd9;
  localparam kind_t KIND_COMMA  = 4'd10;
  localparam kind_t KIND_END    = 4'd11;
  localparam kind_t KIND_ERROR  = 4'd12;

  localparam err_t ERR_NONE      = 3'd0;
  localparam err_t ERR_BAD_CHAR  = 3'd1;
  localparam err_t ERR_NEWLINE   = 3'd2;
  localparam err_t ERR_UNTERM    = 3'd3;
  localparam err_t ERR_LITERAL   = 3'd4;
  localparam err_t ERR_EXPONENT  = 3'd5;

  localparam sel_t LIT_TRUE  = 2'd0;
  localparam sel_t LIT_FALSE = 2'd1;
  localparam sel_t LIT_NULL  = 2'd2;

  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_0      = 8'h30;
  localparam char_t CH_9      = 8'h39;
  localparam char_t CH_COLON  = 8'h3A;
  localparam char_t CH_UP_E   = 8'h45;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_A      = 8'h61;
  localparam char_t CH_E      = 8'h65;
  localparam char_t CH_F      = 8'h66;
  localparam char_t CH_L      = 8'h6C;
  localparam char_t CH_N      = 8'h6E;
  localparam char_t CH_R      = 8'h72;
  localparam char_t CH_S      = 8'h73;
  localparam char_t CH_T      = 8'h74;
  localparam char_t CH_U      = 8'h75;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;

  function automatic char_t lit_char(sel_t sel, prog_t prog);
    char_t ch;
    ch = 8'h00;
    unique case (sel)
      LIT_TRUE: begin
        case (prog)
          3'd0: ch = CH_T;
          3'd1: ch = CH_R;
          3'd2: ch = CH_U;
          3'd3: ch = CH_E;
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (prog)
          3'd0: ch = CH_F;
          3'd1: ch = CH_A;
          3'd2: ch = CH_L;
          3'd3: ch = CH_S;
          3'd4: ch = CH_E;
          default: ch = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (prog)
          3'd0: ch = CH_N;
          3'd1: ch = CH_U;
          3'd2: ch = CH_L;
          3'd3: ch = CH_L;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic prog_t lit_len(sel_t sel);
    return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic kind_t lit_kind(sel_t sel);
    return (sel == LIT_NULL) ? KIND_NULL : KIND_BOOL;
  endfunction

  function automatic kind_t punct_kind(char_t c);
    kind_t k;
    unique case (c)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_COLON:  k = KIND_COLON;
      default:   k = KIND_COMMA;
    endcase
    return k;
  endfunction

  function automatic rec_t mk_rec(kind_t kind, pos_t s, pos_t e, err_t err);
    rec_t r;
    r.kind      = kind;
    r.start_ofs = 32'(s);
    r.end_ofs   = 32'(e);
    r.err       = err;
    return r;
  endfunction

endpackage

@@ rtl/json_token_lexer_unit.sv @@
// JSON token lexer: one byte per request in, token records out.
// Depends on jtl_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------------
//  in       | in_valid / in_ready | text_byte, byte_valid, doc_last
//  out      | out_valid/out_ready | token_kind, start_offset, end_offset, error_code,
//           |                     | run_last
//
// A request is decoded in the cycle it is accepted; its zero to three records land in a
// three-entry result buffer and leave one per cycle while out_ready is high.
// One request per cycle while each yields at most one record and out_ready is high; a
// request with more records holds the input while they leave by the buffer's single output port.
// rst (synchronous) empties the buffer and returns the lexer to between-token state.
// A stalled output holds the buffer; the input is taken again once one record remains
// and is being taken.
module json_token_lexer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        byte_valid,
  input  logic        doc_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [31:0] start_offset,
  output logic [31:0] end_offset,
  output logic [2:0]  error_code,
  output logic        run_last
);

  jtl_pkg::mode_t mode, mode_mid, mode_next;
  jtl_pkg::pos_t  byte_position, byte_position_next;
  jtl_pkg::pos_t  token_start, start_mid, token_start_next;
  jtl_pkg::sel_t  literal_select, sel_mid, literal_select_next;
  jtl_pkg::prog_t literal_progress, prog_mid, literal_progress_next;
  logic           halted, halt_mid, halted_next;

  jtl_pkg::rec_t  slot [0:2];
  jtl_pkg::rec_t  fill [0:2];
  jtl_pkg::rec_t  cand [0:3];
  logic [3:0]     cand_vld;
  logic [2:0]     n_res;
  logic [1:0]     cnt;

  jtl_pkg::pos_t  pos_inc, pos_fin;
  jtl_pkg::prog_t prog_inc;
  logic           accept, pop, active, reproc;
  logic           is_digit, is_ws, is_punct, is_litstart, is_numstart, is_bad;
  logic           lit_match, lit_done;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign active   = byte_valid && !halted;

  assign pos_inc  = byte_position + jtl_pkg::pos_t'(1);
  assign pos_fin  = byte_valid ? pos_inc : byte_position;
  assign prog_inc = literal_progress + 3'd1;

  assign is_digit    = (text_byte >= jtl_pkg::CH_0) && (text_byte <= jtl_pkg::CH_9);
  assign is_ws       = (text_byte == jtl_pkg::CH_SPACE) || (text_byte == jtl_pkg::CH_TAB) ||
                       (text_byte == jtl_pkg::CH_CR) || (text_byte == jtl_pkg::CH_LF);
  assign is_punct    = (text_byte == jtl_pkg::CH_LBRACE) || (text_byte == jtl_pkg::CH_RBRACE) ||
                       (text_byte == jtl_pkg::CH_LBRACK) || (text_byte == jtl_pkg::CH_RBRACK) ||
                       (text_byte == jtl_pkg::CH_COLON) || (text_byte == jtl_pkg::CH_COMMA);
  assign is_litstart = (text_byte == jtl_pkg::CH_T) || (text_byte == jtl_pkg::CH_F) ||
                       (text_byte == jtl_pkg::CH_N);
  assign is_numstart = is_digit || (text_byte == jtl_pkg::CH_MINUS);
  assign is_bad      = !(is_ws || is_punct || is_litstart || is_numstart ||
                         (text_byte == jtl_pkg::CH_QUOTE));

  assign lit_match = (text_byte == jtl_pkg::lit_char(literal_select, literal_progress));
  assign lit_done  = (prog_inc >= jtl_pkg::lit_len(literal_select));

  // byte phase of the next state
  always_comb begin
    mode_mid = mode;
    halt_mid = halted;
    start_mid = token_start;
    sel_mid = literal_select;
    prog_mid = literal_progress;
    reproc = 1'b0;
    if (active) begin
      unique case (mode)
        jtl_pkg::M_INT: begin
          if (text_byte == jtl_pkg::CH_DOT) mode_mid = jtl_pkg::M_FRAC;
          else if (!is_digit) reproc = 1'b1;
        end
        jtl_pkg::M_FRAC: begin
          if ((text_byte == jtl_pkg::CH_E) || (text_byte == jtl_pkg::CH_UP_E)) begin
            mode_mid = jtl_pkg::M_EXPS;
          end else if (!is_digit) begin
            reproc = 1'b1;
          end
        end
        jtl_pkg::M_EXPS: begin
          if ((text_byte == jtl_pkg::CH_PLUS) || (text_byte == jtl_pkg::CH_MINUS)) begin
            mode_mid = jtl_pkg::M_EXPSIGN;
          end else if (is_digit) begin
            mode_mid = jtl_pkg::M_EXPD;
          end else begin
            reproc = 1'b1;
          end
        end
        jtl_pkg::M_EXPSIGN: begin
          if (is_digit) mode_mid = jtl_pkg::M_EXPD;
          else reproc = 1'b1;
        end
        jtl_pkg::M_EXPD: begin
          if (!is_digit) reproc = 1'b1;
        end
        jtl_pkg::M_STR: begin
          if (text_byte == jtl_pkg::CH_BSLASH) begin
            mode_mid = jtl_pkg::M_ESC;
          end else if (text_byte == jtl_pkg::CH_LF) begin
            halt_mid = 1'b1;
            mode_mid = jtl_pkg::M_IDLE;
          end else if (text_byte == jtl_pkg::CH_QUOTE) begin
            mode_mid = jtl_pkg::M_IDLE;
          end
        end
        jtl_pkg::M_ESC: mode_mid = jtl_pkg::M_STR;
        jtl_pkg::M_LIT: begin
          if (lit_match) begin
            prog_mid = prog_inc;
            if (lit_done) mode_mid = jtl_pkg::M_IDLE;
          end else begin
            halt_mid = 1'b1;
            mode_mid = jtl_pkg::M_IDLE;
          end
        end
        default: reproc = 1'b1;
      endcase
      if (reproc) begin
        mode_mid = jtl_pkg::M_IDLE;
        if (text_byte == jtl_pkg::CH_QUOTE) begin
          start_mid = pos_inc;
          mode_mid = jtl_pkg::M_STR;
        end else if (is_litstart) begin
          sel_mid = (text_byte == jtl_pkg::CH_T) ? jtl_pkg::LIT_TRUE :
                    (text_byte == jtl_pkg::CH_F) ? jtl_pkg::LIT_FALSE : jtl_pkg::LIT_NULL;
          prog_mid = 3'd1;
          start_mid = byte_position;
          mode_mid = jtl_pkg::M_LIT;
        end else if (is_numstart) begin
          start_mid = byte_position;
          mode_mid = jtl_pkg::M_INT;
        end else if (is_bad) begin
          halt_mid = 1'b1;
        end
      end
    end
  end

  // document end clears everything
  always_comb begin
    mode_next = mode_mid;
    halted_next = halt_mid;
    token_start_next = start_mid;
    literal_select_next = sel_mid;
    literal_progress_next = prog_mid;
    byte_position_next = pos_fin;
    if (doc_last) begin
      mode_next = jtl_pkg::M_IDLE;
      halted_next = 1'b0;
      token_start_next = '0;
      literal_select_next = '0;
      literal_progress_next = '0;
      byte_position_next = '0;
    end
  end

  // result records, in emission order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    cand_vld = '0;

    if (active) begin
      unique case (mode)
        jtl_pkg::M_INT: begin
          cand_vld[0] = reproc;
          cand[0] = jtl_pkg::mk_rec(jtl_pkg::KIND_INT, token_start, byte_position,
                                    jtl_pkg::ERR_NONE);
        end
        jtl_pkg::M_FRAC, jtl_pkg::M_EXPD: begin
          cand_vld[0] = reproc;
          cand[0] = jtl_pkg::mk_rec(jtl_pkg::KIND_FLOAT, token_start, byte_position,
                                    jtl_pkg::ERR_NONE);
        end
        jtl_pkg::M_EXPS, jtl_pkg::M_EXPSIGN: begin
          cand_vld[0] = reproc;
          cand[0] = jtl_pkg::mk_rec(jtl_pkg::KIND_FLOAT, token_start, byte_position,
                                    jtl_pkg::ERR_EXPONENT);
        end
        jtl_pkg::M_STR: begin
          if (text_byte == jtl_pkg::CH_LF) begin
            cand_vld[0] = 1'b1;
            cand[0] = jtl_pkg::mk_rec(jtl_pkg::KIND_ERROR, token_start, pos_inc,
                                      jtl_pkg::ERR_NEWLINE);
          end else if (text_byte == jtl_pkg::CH_QUOTE) begin
            cand_vld[0] = 1'b1;
            cand[0] = jtl_pkg::mk_rec(jtl_pkg::KIND_STRING, token_start, byte_position,
                                      jtl_pkg::ERR_NONE);
          end
        end
        jtl_pkg::M_LIT: begin
          if (!lit_match) begin
            cand_vld[0] = 1'b1;
            cand[0] = jtl_pkg::mk_rec(jtl_pkg::KIND_ERROR, token_start, pos_inc,
                                      jtl_pkg::ERR_LITERAL);
          end else if (lit_done) begin
            cand_vld[0] = 1'b1;
            cand[0] = jtl_pkg::mk_rec(jtl_pkg::lit_kind(literal_select), token_start,
                                      pos_inc, jtl_pkg::ERR_NONE);
          end
        end
        default: cand_vld[0] = 1'b0;
      endcase
    end

    if (reproc && is_punct) begin
      cand_vld[1] = 1'b1;
      cand[1] = jtl_pkg::mk_rec(jtl_pkg::punct_kind(text_byte), byte_position, pos_inc,
                                jtl_pkg::ERR_NONE);
    end else if (reproc && is_bad) begin
      cand_vld[1] = 1'b1;
      cand[1] = jtl_pkg::mk_rec(jtl_pkg::KIND_ERROR, byte_position, pos_inc,
                                jtl_pkg::ERR_BAD_CHAR);
    end

    if (doc_last && !halt_mid) begin
      unique case (mode_mid)
        jtl_pkg::M_INT: begin
          cand_vld[2] = 1'b1;
          cand[2] = jtl_pkg::mk_rec(jtl_pkg::KIND_INT, start_mid, pos_fin, jtl_pkg::ERR_NONE);
        end
        jtl_pkg::M_FRAC, jtl_pkg::M_EXPD: begin
          cand_vld[2] = 1'b1;
          cand[2] = jtl_pkg::mk_rec(jtl_pkg::KIND_FLOAT, start_mid, pos_fin,
                                    jtl_pkg::ERR_NONE);
        end
        jtl_pkg::M_EXPS, jtl_pkg::M_EXPSIGN: begin
          cand_vld[2] = 1'b1;
          cand[2] = jtl_pkg::mk_rec(jtl_pkg::KIND_FLOAT, start_mid, pos_fin,
                                    jtl_pkg::ERR_EXPONENT);
        end
        jtl_pkg::M_STR, jtl_pkg::M_ESC: begin
          cand_vld[2] = 1'b1;
          cand[2] = jtl_pkg::mk_rec(jtl_pkg::KIND_ERROR, start_mid, pos_fin,
                                    jtl_pkg::ERR_UNTERM);
        end
        jtl_pkg::M_LIT: begin
          cand_vld[2] = 1'b1;
          cand[2] = jtl_pkg::mk_rec(jtl_pkg::KIND_ERROR, start_mid, pos_fin,
                                    jtl_pkg::ERR_LITERAL);
        end
        default: cand_vld[2] = 1'b0;
      endcase
    end

    if (doc_last) begin
      cand_vld[3] = 1'b1;
      cand[3] = jtl_pkg::mk_rec(jtl_pkg::KIND_END, pos_fin, pos_fin, jtl_pkg::ERR_NONE);
    end
  end

  // pack present records into the front of the buffer
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fill[i] = '0;
    end
    n_res = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i]) begin
        if (n_res < 3'd3) fill[n_res[1:0]] = cand[i];
        n_res = n_res + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jtl_pkg::M_IDLE;
      halted <= 1'b0;
      byte_position <= '0;
      token_start <= '0;
      literal_select <= '0;
      literal_progress <= '0;
      cnt <= '0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        halted <= halted_next;
        byte_position <= byte_position_next;
        token_start <= token_start_next;
        literal_select <= literal_select_next;
        literal_progress <= literal_progress_next;
        cnt <= n_res[1:0];
      end else if (pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[0] <= fill[0];
      slot[1] <= fill[1];
      slot[2] <= fill[2];
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign out_valid    = (cnt != 2'd0);
  assign token_kind   = slot[0].kind;
  assign start_offset = slot[0].start_ofs;
  assign end_offset   = slot[0].end_ofs;
  assign error_code   = slot[0].err;
  assign run_last     = (cnt == 2'd1);

endmodule

@@ rtl/jtl_checker.sv @@
// Port-level checks for json_token_lexer_unit, attached by bind.
// Depends on jtl_pkg and json_token_lexer_unit_macros.svh.
`include "json_token_lexer_unit_macros.svh"

module jtl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [31:0] start_offset,
  input logic [31:0] end_offset,
  input logic [2:0]  error_code,
  input logic        run_last
);

  `JTL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(start_offset) && $stable(end_offset))
  `JTL_ASSERT_NOW(a_ready_when_drained, clk, rst, !in_ready, out_valid)
  `JTL_ASSERT_NOW(a_end_closes_run, clk, rst, out_valid && (token_kind == jtl_pkg::KIND_END), run_last && (start_offset == end_offset) && (error_code == jtl_pkg::ERR_NONE))
  `JTL_ASSERT_NOW(a_error_has_code, clk, rst, out_valid && (token_kind == jtl_pkg::KIND_ERROR), error_code != jtl_pkg::ERR_NONE)

endmodule

bind json_token_lexer_unit jtl_checker u_jtl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .token_kind   (token_kind),
  .start_offset (start_offset),
  .end_offset   (end_offset),
  .error_code   (error_code),
  .run_last     (run_last)
);
